>>> rtl/core/ist_pkg.sv
// Shared types and constants of the integer set table.
// Used by ist_ctrl, ist_dp and integer_set_table_unit; depends on nothing.
package ist_pkg;

    // set size and derived widths
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int COUNT_W  = 7;

    // request codes (code 3 behaves as a lookup)
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture a new request, restart the scan
        logic scan;    // walk the stored entries
        logic commit;  // write back, update count, load result register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;  // every stored entry has been examined
        logic out_free;   // result register can take a new result
    } t_dp_sts;

endpackage

>>> rtl/core/ist_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module ist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/ist_ctrl.sv
// Sequencer of the integer set table: accept, scan, commit.
// Depends on ist_pkg for the command and status structs.
module ist_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ist_pkg::t_dp_sts i_sts,
    output ist_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // hold until the result register is free
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/ist_dp.sv
// Datapath of the integer set table: entry memory, scan, min/max, result register.
// Depends on ist_pkg and ist_ram.
module ist_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ist_pkg::t_dp_cmd             i_cmd,
    output ist_pkg::t_dp_sts             o_sts,
    input  logic [ist_pkg::OP_W-1:0]     i_operation,
    input  logic signed [ist_pkg::DATA_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_was_present,
    output logic [ist_pkg::ST_W-1:0]     o_status,
    output logic [ist_pkg::COUNT_W-1:0]  o_count,
    output logic signed [ist_pkg::DATA_W-1:0] o_smallest,
    output logic signed [ist_pkg::DATA_W-1:0] o_largest
);

    localparam int AW = ist_pkg::ADDR_W;
    localparam int CW = ist_pkg::CNT_W;
    localparam int DW = ist_pkg::DATA_W;

    // control state
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_rd_vld;
    logic          r_out_vld;

    // request and scan payload
    logic [ist_pkg::OP_W-1:0] r_op;
    logic signed [DW-1:0]     r_val;
    logic [CW-1:0]            r_issue;
    logic [CW-1:0]            r_rd_idx;
    logic                     r_present;
    logic [AW-1:0]            r_slot;
    logic signed [DW-1:0]     r_last;
    logic                     r_any;
    logic signed [DW-1:0]     r_min;
    logic signed [DW-1:0]     r_max;

    // result register payload
    logic                     r_res_present;
    logic [ist_pkg::ST_W-1:0] r_res_status;
    logic [CW-1:0]            r_res_count;
    logic signed [DW-1:0]     r_res_min;
    logic signed [DW-1:0]     r_res_max;

    // memory port signals
    logic                 rd_en;
    logic signed [DW-1:0] rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [DW-1:0] wr_data;

    // request outcome
    logic                     room;
    logic                     inserted;
    logic                     deleted;
    logic                     holds_val;
    logic [ist_pkg::ST_W-1:0] status;
    logic signed [DW-1:0]     fin_min;
    logic signed [DW-1:0]     fin_max;

    ist_ram #(
        .WIDTH(DW),
        .DEPTH(ist_pkg::CAPACITY)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_issue[AW-1:0]),
        .o_rd_data(rd_data)
    );

    // scan issues one read per cycle while entries remain
    assign rd_en = i_cmd.scan && (r_issue < r_cnt);

    assign o_sts.scan_done = (r_issue >= r_cnt) && !r_rd_vld;
    assign o_sts.out_free  = !r_out_vld || i_ready;

    // outcome of the request, valid once the scan is done
    assign room      = r_cnt < CW'(ist_pkg::CAPACITY);
    assign inserted  = (r_op == ist_pkg::OP_INSERT) && !r_present && room;
    assign deleted   = (r_op == ist_pkg::OP_DELETE) && r_present;
    assign holds_val = inserted || (r_present && (r_op != ist_pkg::OP_DELETE));

    always_comb begin
        status = ist_pkg::ST_OK;
        if ((r_op == ist_pkg::OP_INSERT) && !r_present && !room) begin
            status = ist_pkg::ST_FULL;
        end else if ((r_op == ist_pkg::OP_DELETE) && (r_cnt == '0)) begin
            status = ist_pkg::ST_EMPTY;
        end
    end

    // new count
    always_comb begin
        n_cnt = r_cnt;
        if (inserted) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (deleted) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    // min/max of the set afterwards: entries other than the value, plus the
    // value itself when the set holds it
    always_comb begin
        fin_min = '0;
        fin_max = '0;
        if (r_any && holds_val) begin
            fin_min = (r_val < r_min) ? r_val : r_min;
            fin_max = (r_val > r_max) ? r_val : r_max;
        end else if (r_any) begin
            fin_min = r_min;
            fin_max = r_max;
        end else if (holds_val) begin
            fin_min = r_val;
            fin_max = r_val;
        end
    end

    // write back: append on insert, move last entry into the hole on delete
    assign wr_en   = i_cmd.commit && (inserted || deleted);
    assign wr_addr = inserted ? r_cnt[AW-1:0] : r_slot;
    assign wr_data = inserted ? r_val : r_last;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (i_cmd.commit) begin
                r_cnt     <= n_cnt;
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // request capture and scan accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_val     <= i_value;
            r_issue   <= '0;
            r_present <= 1'b0;
            r_any     <= 1'b0;
        end else begin
            if (rd_en) begin
                r_issue <= CW'(r_issue + 1'b1);
            end
            if (r_rd_vld) begin
                if (rd_data == r_val) begin
                    r_present <= 1'b1;
                    r_slot    <= r_rd_idx[AW-1:0];
                end else begin
                    if (!r_any || (rd_data < r_min)) begin
                        r_min <= rd_data;
                    end
                    if (!r_any || (rd_data > r_max)) begin
                        r_max <= rd_data;
                    end
                    r_any <= 1'b1;
                end
                if (CW'(r_rd_idx + 1'b1) == r_cnt) begin
                    r_last <= rd_data;
                end
            end
        end
        r_rd_idx <= r_issue;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_present <= r_present;
            r_res_status  <= status;
            r_res_count   <= n_cnt;
            r_res_min     <= fin_min;
            r_res_max     <= fin_max;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_was_present = r_res_present;
    assign o_status      = r_res_status;
    assign o_count       = ist_pkg::COUNT_W'(r_res_count);
    assign o_smallest    = r_res_min;
    assign o_largest     = r_res_max;

endmodule

>>> rtl/core/integer_set_table_unit.sv
// Top level of the integer set table: controller plus datapath.
// Depends on ist_pkg, ist_ctrl, ist_dp (and ist_ram through ist_dp).
//
// Keeps an unordered set of up to 64 distinct signed 32-bit values. Each
// transaction inserts, deletes or looks up one value and returns one result:
// whether the value was present before, a status (ok, insert refused because
// full, delete on empty set), the count afterwards, and the minimum and
// maximum afterwards (both 0 for an empty set). The entry memory has a single
// read port and the scan reads one stored entry per cycle for the membership
// check and the min/max; after the scan the last read drains, the controller
// moves to write back, and the write back loads the result. The input is
// ready again the cycle after that; a result still waiting for the receiver
// holds the next write back. A new request is taken while a finished result
// still waits in the output register. No clearing pass is needed after reset.
module integer_set_table_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ist_pkg::OP_W-1:0]          i_operation,
    input  logic signed [ist_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_was_present,
    output logic [ist_pkg::ST_W-1:0]          o_status,
    output logic [ist_pkg::COUNT_W-1:0]       o_count,
    output logic signed [ist_pkg::DATA_W-1:0] o_smallest,
    output logic signed [ist_pkg::DATA_W-1:0] o_largest
);

    ist_pkg::t_dp_cmd cmd;
    ist_pkg::t_dp_sts sts;

    ist_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    ist_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_operation  (i_operation),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_was_present(o_was_present),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_smallest   (o_smallest),
        .o_largest    (o_largest)
    );

endmodule
